@@ rtl/core/cfp_pkg.sv @@
// ----------------------------------------------------------------------------
// cfp_pkg: shared types and constants for the command frame parser
// Frame layout: A5 5A, 16-bit little-endian length, payload, 5A A5.
// ----------------------------------------------------------------------------
package cfp_pkg;

  localparam int PAYLOAD_MAX = 64;
  localparam int HEAD_KEEP   = 5;
  localparam int LEN_W       = $clog2(PAYLOAD_MAX + 1);
  localparam int HEAD_IDX_W  = $clog2(HEAD_KEEP);

  localparam logic [7:0]  SYNC_A      = 8'hA5;
  localparam logic [7:0]  SYNC_B      = 8'h5A;
  localparam logic [15:0] COUNT_LIMIT = 16'hFFFF;

  localparam logic [7:0] CMD_T = 8'h54;
  localparam logic [7:0] CMD_P = 8'h50;
  localparam logic [7:0] CMD_G = 8'h47;
  localparam logic [7:0] CMD_M = 8'h4D;
  localparam logic [7:0] CMD_A = 8'h41;

  localparam logic [LEN_W-1:0] LEN_MIN_T  = LEN_W'(5);
  localparam logic [LEN_W-1:0] LEN_MIN_P  = LEN_W'(6);
  localparam logic [LEN_W-1:0] LEN_MIN_GM = LEN_W'(2);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_LEN_LO  = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_TRAIL1  = 3'd5,
    PH_TRAIL2  = 3'd6
  } phase_t;

  // Completed frame handed from framer to executor.
  typedef struct packed {
    logic                          done;
    logic [LEN_W-1:0]              length;
    logic [HEAD_KEEP-1:0][7:0]     head;
  } frame_t;

  // One result request.
  typedef struct packed {
    logic [7:0]  command_code;
    logic        accepted;
    logic [31:0] echo_word;
    logic [7:0]  last_command;
    logic [15:0] command_total;
  } result_t;

endpackage

@@ rtl/core/command_frame_parser.sv @@
// ----------------------------------------------------------------------------
// command_frame_parser: byte-stream command frame parser, top level
// Path: the closing trailer byte is held in the input register, and its result
//   is captured in the result register once the pipe advances.
// Throughput: one byte per cycle; the input register, frame FSM and
//   result register advance together whenever the result slot is free.
// Reset: synchronous active-low rst_n clears parser state, echo, last code,
//   count and both valid flags; the payload head store is not cleared.
// ----------------------------------------------------------------------------
module command_frame_parser (
  input  logic        clk,
  input  logic        rst_n,
  // byte input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  // result channel, one request per completed frame
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_command_code,
  output logic        out_accepted,
  output logic [31:0] out_echo_word,
  output logic [7:0]  out_last_command,
  output logic [15:0] out_command_total
);

  // Whole pipe moves when the result slot is empty or being taken.
  logic adv;
  logic step;

  logic       in_valid_r;
  logic [7:0] in_byte_r;

  cfp_pkg::frame_t  frame;
  cfp_pkg::result_t result;

  logic             out_valid_r;
  cfp_pkg::result_t out_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  // The FSM only consumes a byte when the pipe advances.
  assign step     = adv && in_valid_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (adv) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) in_byte_r <= in_rx_byte;
  end

  cfp_framer u_framer (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .rx_byte (in_byte_r),
    .frame   (frame)
  );

  // frame.done is already qualified by step
  cfp_executor u_executor (
    .clk    (clk),
    .rst_n  (rst_n),
    .frame  (frame),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= frame.done;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && frame.done) out_r <= result;
  end

  assign out_valid         = out_valid_r;
  assign out_command_code  = out_r.command_code;
  assign out_accepted      = out_r.accepted;
  assign out_echo_word     = out_r.echo_word;
  assign out_last_command  = out_r.last_command;
  assign out_command_total = out_r.command_total;

endmodule

@@ rtl/core/cfp_framer.sv @@
// ----------------------------------------------------------------------------
// cfp_framer: byte-level frame state machine
// Tracks sync, length, payload head and trailer; flags a completed frame.
// ----------------------------------------------------------------------------
module cfp_framer (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      rx_byte,
  output cfp_pkg::frame_t frame
);

  cfp_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]                   length_low_r, length_low_nxt;
  logic [cfp_pkg::LEN_W-1:0]    frame_length_r, frame_length_nxt;
  logic [cfp_pkg::LEN_W-1:0]    bytes_taken_r, bytes_taken_nxt;
  logic [cfp_pkg::HEAD_KEEP-1:0][7:0] head_r;
  logic [15:0]                  len_full;
  logic                         head_wr;
  logic                         done;

  assign len_full = {rx_byte, length_low_r};
  assign head_wr  = step && (phase_r == cfp_pkg::PH_PAYLOAD) &&
                    (bytes_taken_r < cfp_pkg::LEN_W'(cfp_pkg::HEAD_KEEP));

  always_comb begin
    phase_nxt        = phase_r;
    length_low_nxt   = length_low_r;
    frame_length_nxt = frame_length_r;
    bytes_taken_nxt  = bytes_taken_r;
    done             = 1'b0;
    if (step) begin
      unique case (phase_r)
        cfp_pkg::PH_IDLE: begin
          if (rx_byte == cfp_pkg::SYNC_A) phase_nxt = cfp_pkg::PH_SYNC2;
        end
        cfp_pkg::PH_SYNC2: begin
          if (rx_byte == cfp_pkg::SYNC_B)      phase_nxt = cfp_pkg::PH_LEN_LO;
          else if (rx_byte == cfp_pkg::SYNC_A) phase_nxt = cfp_pkg::PH_SYNC2;
          else                                 phase_nxt = cfp_pkg::PH_IDLE;
        end
        cfp_pkg::PH_LEN_LO: begin
          length_low_nxt = rx_byte;
          phase_nxt      = cfp_pkg::PH_LEN_HI;
        end
        cfp_pkg::PH_LEN_HI: begin
          if (len_full == 16'd0 || len_full > 16'(cfp_pkg::PAYLOAD_MAX)) begin
            phase_nxt = cfp_pkg::PH_IDLE;
          end else begin
            frame_length_nxt = len_full[cfp_pkg::LEN_W-1:0];
            bytes_taken_nxt  = '0;
            phase_nxt        = cfp_pkg::PH_PAYLOAD;
          end
        end
        cfp_pkg::PH_PAYLOAD: begin
          bytes_taken_nxt = bytes_taken_r + 1'b1;
          if (bytes_taken_nxt >= frame_length_r) phase_nxt = cfp_pkg::PH_TRAIL1;
        end
        cfp_pkg::PH_TRAIL1: begin
          phase_nxt = (rx_byte == cfp_pkg::SYNC_B) ? cfp_pkg::PH_TRAIL2
                                                   : cfp_pkg::PH_IDLE;
        end
        cfp_pkg::PH_TRAIL2: begin
          phase_nxt = cfp_pkg::PH_IDLE;
          done      = (rx_byte == cfp_pkg::SYNC_A);
        end
        default: phase_nxt = cfp_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= cfp_pkg::PH_IDLE;
      length_low_r   <= '0;
      frame_length_r <= '0;
      bytes_taken_r  <= '0;
    end else begin
      phase_r        <= phase_nxt;
      length_low_r   <= length_low_nxt;
      frame_length_r <= frame_length_nxt;
      bytes_taken_r  <= bytes_taken_nxt;
    end
  end

  // Head bytes: no reset, every byte read was written in the same frame.
  always_ff @(posedge clk) begin
    if (head_wr) head_r[bytes_taken_r[cfp_pkg::HEAD_IDX_W-1:0]] <= rx_byte;
  end

  assign frame.done   = done;
  assign frame.length = frame_length_r;
  assign frame.head   = head_r;

endmodule

@@ rtl/core/cfp_executor.sv @@
// ----------------------------------------------------------------------------
// cfp_executor: command decode and architectural registers
// Checks command length, updates echo/last/count, builds the result.
// ----------------------------------------------------------------------------
module cfp_executor (
  input  logic             clk,
  input  logic             rst_n,
  input  cfp_pkg::frame_t  frame,
  output cfp_pkg::result_t result
);

  logic [31:0] echo_r, echo_nxt;
  logic [7:0]  last_r, last_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  code;
  logic        ok;
  logic        load_echo;

  assign code = frame.head[0];

  always_comb begin
    ok        = 1'b0;
    load_echo = 1'b0;
    unique case (code) inside
      cfp_pkg::CMD_T: begin
        ok        = (frame.length >= cfp_pkg::LEN_MIN_T);
        load_echo = ok;
      end
      cfp_pkg::CMD_P: ok = (frame.length >= cfp_pkg::LEN_MIN_P);
      cfp_pkg::CMD_G,
      cfp_pkg::CMD_M: ok = (frame.length >= cfp_pkg::LEN_MIN_GM);
      cfp_pkg::CMD_A: ok = 1'b1;
      default:        ok = 1'b0;
    endcase
  end

  always_comb begin
    echo_nxt  = echo_r;
    last_nxt  = last_r;
    count_nxt = count_r;
    if (frame.done && ok) begin
      last_nxt = code;
      if (count_r < cfp_pkg::COUNT_LIMIT) count_nxt = count_r + 16'd1;
      if (load_echo) echo_nxt = {frame.head[4], frame.head[3],
                                 frame.head[2], frame.head[1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      echo_r  <= '0;
      last_r  <= '0;
      count_r <= '0;
    end else begin
      echo_r  <= echo_nxt;
      last_r  <= last_nxt;
      count_r <= count_nxt;
    end
  end

  assign result.command_code  = code;
  assign result.accepted      = ok;
  assign result.echo_word     = echo_nxt;
  assign result.last_command  = last_nxt;
  assign result.command_total = count_nxt;

endmodule

@@ rtl/core/cfp_checker.sv @@
// ----------------------------------------------------------------------------
// cfp_checker: port-level assertions for command_frame_parser
// Bound to the top level; watches the handshakes and result fields.
// ----------------------------------------------------------------------------
module cfp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_command_code,
  input logic        out_accepted,
  input logic [31:0] out_echo_word,
  input logic [7:0]  out_last_command,
  input logic [15:0] out_command_total
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_command_code) &&
      $stable(out_accepted) && $stable(out_echo_word) &&
      $stable(out_last_command) && $stable(out_command_total))
    else $error("result changed while stalled");

  // input backpressure only from a blocked result slot
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with free result slot");

  // an accepted command becomes the last command
  a_last_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_last_command == out_command_code)
    else $error("last command mismatch");

  // an accepted command leaves a nonzero count
  a_count_nz: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_command_total != 16'd0)
    else $error("accepted command with zero count");

  // reset empties the result slot
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind command_frame_parser cfp_checker u_cfp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_command_code  (out_command_code),
  .out_accepted      (out_accepted),
  .out_echo_word     (out_echo_word),
  .out_last_command  (out_last_command),
  .out_command_total (out_command_total)
);

@@ tb/sv/tb_command_frame_parser.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_command_frame_parser: self-checking bench for the command frame parser
// Sends byte streams of well-formed and broken frames through the input
// channel. Random gaps on the input side and random stalls on the result side.
// A bench-side frame tracker predicts every result, and the checker compares
// each result field by field, in order.
// ----------------------------------------------------------------------------
module tb_command_frame_parser;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int TAIL_CYCLES = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_command_code;
  logic        out_accepted;
  logic [31:0] out_echo_word;
  logic [7:0]  out_last_command;
  logic [15:0] out_command_total;

  command_frame_parser uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_command_code  (out_command_code),
    .out_accepted      (out_accepted),
    .out_echo_word     (out_echo_word),
    .out_last_command  (out_last_command),
    .out_command_total (out_command_total)
  );

  always #10 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench-side frame tracker: mirrors the parser state byte by byte.
  // --------------------------------------------------------------------------
  cfp_pkg::phase_t  trk_phase = cfp_pkg::PH_IDLE;
  logic [7:0]       trk_len_lo = 8'h00;
  int               trk_frame_len = 0;
  int               trk_taken = 0;
  logic [7:0]       trk_head [cfp_pkg::HEAD_KEEP];
  logic [31:0]      trk_echo = 32'h0;
  logic [7:0]       trk_last = 8'h00;
  logic [15:0]      trk_total = 16'h0;

  cfp_pkg::result_t pending_results [$];   // results owed by the parser, oldest first
  cfp_pkg::result_t owed;

  // knobs and bookkeeping
  bit          src_idle_on = 1'b1;
  bit          sink_stall_on = 1'b1;
  int          sink_roll;
  int          stall_run = 0;
  int          cycle_count = 0;
  int          bytes_sent = 0;
  int          results_checked = 0;
  int          accepted_seen = 0;
  int          mismatches = 0;

  // Advance the tracker by one accepted byte; queue a result when a frame
  // closes with a good trailer.
  task automatic track_rx_byte(input logic [7:0] b);
    logic [15:0]      len;
    cfp_pkg::result_t res;
    bit               ok;
    case (trk_phase)
      cfp_pkg::PH_IDLE: begin
        if (b == cfp_pkg::SYNC_A) trk_phase = cfp_pkg::PH_SYNC2;
      end
      cfp_pkg::PH_SYNC2: begin
        // a repeated A5 keeps the parser hunting for 5A
        if (b == cfp_pkg::SYNC_B) trk_phase = cfp_pkg::PH_LEN_LO;
        else if (b != cfp_pkg::SYNC_A) trk_phase = cfp_pkg::PH_IDLE;
      end
      cfp_pkg::PH_LEN_LO: begin
        trk_len_lo = b;
        trk_phase  = cfp_pkg::PH_LEN_HI;
      end
      cfp_pkg::PH_LEN_HI: begin
        len = {b, trk_len_lo};
        if (len == 16'd0 || len > cfp_pkg::PAYLOAD_MAX) begin
          trk_phase = cfp_pkg::PH_IDLE;            // frame dropped
        end else begin
          trk_frame_len = len;
          trk_taken     = 0;
          trk_phase     = cfp_pkg::PH_PAYLOAD;
        end
      end
      cfp_pkg::PH_PAYLOAD: begin
        if (trk_taken < cfp_pkg::HEAD_KEEP) trk_head[trk_taken] = b;
        trk_taken++;
        if (trk_taken >= trk_frame_len) trk_phase = cfp_pkg::PH_TRAIL1;
      end
      cfp_pkg::PH_TRAIL1: begin
        trk_phase = (b == cfp_pkg::SYNC_B) ? cfp_pkg::PH_TRAIL2 : cfp_pkg::PH_IDLE;
      end
      cfp_pkg::PH_TRAIL2: begin
        trk_phase = cfp_pkg::PH_IDLE;
        if (b == cfp_pkg::SYNC_A) begin
          ok = 1'b0;
          case (trk_head[0]) inside
            cfp_pkg::CMD_T: begin
              if (trk_frame_len >= cfp_pkg::LEN_MIN_T) begin
                trk_echo = {trk_head[4], trk_head[3], trk_head[2], trk_head[1]};
                ok = 1'b1;
              end
            end
            cfp_pkg::CMD_P: ok = (trk_frame_len >= cfp_pkg::LEN_MIN_P);
            cfp_pkg::CMD_G,
            cfp_pkg::CMD_M: ok = (trk_frame_len >= cfp_pkg::LEN_MIN_GM);
            cfp_pkg::CMD_A: ok = 1'b1;
            default:        ok = 1'b0;
          endcase
          if (ok) begin
            trk_last = trk_head[0];
            if (trk_total != cfp_pkg::COUNT_LIMIT) trk_total++;
          end
          res.command_code  = trk_head[0];
          res.accepted      = ok;
          res.echo_word     = trk_echo;
          res.last_command  = trk_last;
          res.command_total = trk_total;
          pending_results.push_back(res);
        end
      end
      default: trk_phase = cfp_pkg::PH_IDLE;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, mostly short with a few long runs.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || !sink_stall_on) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      out_stall <= 1'b1;
      stall_run <= stall_run - 1;
    end else begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 4) begin
        stall_run <= $urandom_range(5, 30);
        out_stall <= 1'b1;
      end else begin
        out_stall <= (sink_roll < 30);
      end
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 40)
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want,
               cycle_count);
    mismatches++;
  endtask

  // Checker: every accepted result against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with none owed", {24'h0, out_command_code}, 32'h0);
      end else begin
        owed = pending_results.pop_front();
        if (out_command_code !== owed.command_code)
          report_mismatch("command_code", 32'(out_command_code),
                          32'(owed.command_code));
        if (out_accepted !== owed.accepted)
          report_mismatch("accepted", 32'(out_accepted), 32'(owed.accepted));
        if (out_echo_word !== owed.echo_word)
          report_mismatch("echo_word", out_echo_word, owed.echo_word);
        if (out_last_command !== owed.last_command)
          report_mismatch("last_command", 32'(out_last_command),
                          32'(owed.last_command));
        if (out_command_total !== owed.command_total)
          report_mismatch("command_total", 32'(out_command_total),
                          32'(owed.command_total));
        results_checked++;
        if (owed.accepted) accepted_seen++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               pending_results.size());
      $display("tb: failure");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!src_idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // One byte request: optional gap, then hold until the parser takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid   <= 1'b0;
      in_rx_byte <= 8'($urandom_range(0, 255));  // junk while idle
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_rx_byte(b);
    bytes_sent++;
  endtask

  // Full frame: sync, length, payload (code first), trailer bytes as given.
  // fill < 0 means random payload after the code.
  task automatic send_frame(input logic [7:0] code, input int len, input int fill,
                            input logic [7:0] trail1, input logic [7:0] trail2);
    logic [15:0] len_field;
    len_field = 16'(len);
    send_byte(cfp_pkg::SYNC_A);
    send_byte(cfp_pkg::SYNC_B);
    send_byte(len_field[7:0]);
    send_byte(len_field[15:8]);
    for (int i = 0; i < len; i++) begin
      if (i == 0) send_byte(code);
      else if (fill < 0) send_byte(8'($urandom_range(0, 255)));
      else send_byte(fill[7:0]);
    end
    send_byte(trail1);
    send_byte(trail2);
  endtask

  // Sender stops until every owed result is back, then idles for a quiet tail.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Every known command at its minimum length, echo extremes, long payload.
  task automatic test_known_commands();
    send_frame(cfp_pkg::CMD_A, 1, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_G, 2, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_M, 2, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_P, 6, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_T, 5, 8'hFF, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_T, 5, 8'h00, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    // bytes past five dropped
    send_frame(cfp_pkg::CMD_T, 9, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    // largest legal length
    send_frame(cfp_pkg::CMD_T, cfp_pkg::PAYLOAD_MAX, -1, cfp_pkg::SYNC_B,
               cfp_pkg::SYNC_A);
    wait_for_results();
  endtask

  // Short commands and unknown codes still return a result with accepted low.
  task automatic test_rejected_commands();
    send_frame(cfp_pkg::CMD_T, 4, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_P, 5, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_G, 1, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(cfp_pkg::CMD_M, 1, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(8'h00, 3, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_frame(8'hFF, 1, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    wait_for_results();
  endtask

  // Header faults: repeated A5, bad second sync, zero and oversized lengths.
  task automatic test_header_faults();
    send_byte(cfp_pkg::SYNC_A);
    send_byte(cfp_pkg::SYNC_A);
    // A5 A5 A5 5A ... still parses
    send_frame(cfp_pkg::CMD_A, 1, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_byte(cfp_pkg::SYNC_A);
    send_byte(8'h00);                             // bad second sync
    send_frame(cfp_pkg::CMD_G, 2, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    send_byte(cfp_pkg::SYNC_A);
    send_byte(cfp_pkg::SYNC_B);
    send_byte(8'h00);
    send_byte(8'h00);                             // zero length
    send_byte(cfp_pkg::SYNC_A);
    send_byte(cfp_pkg::SYNC_B);
    send_byte(8'(cfp_pkg::PAYLOAD_MAX + 1));
    send_byte(8'h00);                             // one past the maximum
    send_byte(cfp_pkg::SYNC_A);
    send_byte(cfp_pkg::SYNC_B);
    send_byte(8'hFF);
    send_byte(8'hFF);                             // largest length field
    send_frame(cfp_pkg::CMD_A, 1, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    wait_for_results();
  endtask

  // Trailer faults. The bad byte must not be rescanned as a new sync.
  task automatic test_trailer_faults();
    // A5 in first trailer slot
    send_frame(cfp_pkg::CMD_A, 1, -1, cfp_pkg::SYNC_A, cfp_pkg::SYNC_B);
    send_byte(8'h01);
    send_byte(8'h00);
    send_byte(cfp_pkg::CMD_A);
    send_byte(cfp_pkg::SYNC_B);
    send_byte(cfp_pkg::SYNC_A);                   // would close a frame if rescanned
    // bad second trailer byte
    send_frame(cfp_pkg::CMD_M, 2, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_B);
    send_frame(cfp_pkg::CMD_P, 6, -1, cfp_pkg::SYNC_B, 8'h00);
    send_frame(cfp_pkg::CMD_A, 1, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    wait_for_results();
  endtask

  // One random frame, sometimes broken, sometimes preceded by line noise.
  task automatic send_random_frame();
    int          r;
    int          len;
    logic [7:0]  code;
    logic [7:0]  b;
    logic [15:0] bad_len;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 20)
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, cfp_pkg::PAYLOAD_MAX)
                                      : $urandom_range(1, 8);
    case ($urandom_range(0, 7))
      0:       code = cfp_pkg::CMD_T;
      1:       code = cfp_pkg::CMD_P;
      2:       code = cfp_pkg::CMD_G;
      3:       code = cfp_pkg::CMD_M;
      4:       code = cfp_pkg::CMD_A;
      5:       code = cfp_pkg::CMD_T;
      default: code = 8'($urandom_range(0, 255));
    endcase
    if (r < 6) begin
      // dropped length, zero or above the maximum
      bad_len = ($urandom_range(0, 2) == 0)
                ? 16'd0
                : 16'($urandom_range(cfp_pkg::PAYLOAD_MAX + 1, 65535));
      send_byte(cfp_pkg::SYNC_A);
      send_byte(cfp_pkg::SYNC_B);
      send_byte(bad_len[7:0]);
      send_byte(bad_len[15:8]);
    end else if (r < 12) begin
      do b = 8'($urandom_range(0, 255));
      while (b == cfp_pkg::SYNC_A || b == cfp_pkg::SYNC_B);
      send_byte(cfp_pkg::SYNC_A);
      send_byte(b);
    end else if (r < 17) begin
      do b = 8'($urandom_range(0, 255)); while (b == cfp_pkg::SYNC_B);
      send_frame(code, len, -1, b, cfp_pkg::SYNC_A);
    end else if (r < 22) begin
      do b = 8'($urandom_range(0, 255)); while (b == cfp_pkg::SYNC_A);
      send_frame(code, len, -1, cfp_pkg::SYNC_B, b);
    end else begin
      send_frame(code, len, -1, cfp_pkg::SYNC_B, cfp_pkg::SYNC_A);
    end
  endtask

  // Bulk random traffic, idling patterns change every few dozen frames.
  // Halfway through, the sender holds off until the parser has drained.
  task automatic test_random_traffic();
    int first_byte;
    int frame_no;
    bit paused;
    first_byte = bytes_sent;
    frame_no   = 0;
    paused     = 1'b0;
    while (bytes_sent - first_byte < 1280) begin
      if (frame_no % 30 == 0) begin
        src_idle_on   = ($urandom_range(0, 3) != 0);
        sink_stall_on = ($urandom_range(0, 3) != 0);
      end
      send_random_frame();
      frame_no++;
      if (!paused && bytes_sent - first_byte >= 640) begin
        wait_for_results();
        paused = 1'b1;
      end
    end
    src_idle_on   = 1'b1;
    sink_stall_on = 1'b1;
    wait_for_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_known_commands();
    test_rejected_commands();
    test_header_faults();
    test_trailer_faults();
    test_random_traffic();
    wait_for_results();
    $display("run: %0d bytes sent, %0d frame results checked, %0d accepted",
             bytes_sent, results_checked, accepted_seen);
    $display("run: header/trailer faults, short and unknown commands, random stalls");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
